### design/interval_table_insert_merge_query_defines.svh
// Assertion macros for the interval table RTL.
// Depends on nothing; included by interval_table_insert_merge_query.sv, which carries the assertions.
`ifndef INTERVAL_TABLE_INSERT_MERGE_QUERY_DEFINES_SVH
`define INTERVAL_TABLE_INSERT_MERGE_QUERY_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ITIQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ITIQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/itiq_pkg.sv
// Types and codes for the interval table.
// Depends on nothing; used by itiq_cell and the top level.
package itiq_pkg;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_INVERTED = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
  } req_t;

  typedef struct packed {
    logic    hit;
    status_e status;
  } rsp_t;

  // A transaction as it walks along the row of cells.
  typedef struct packed {
    cmd_e               cmd;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic               found;
    logic               err;
  } tok_t;

  // Append write from the top level into one cell.
  typedef struct packed {
    logic               en;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
  } wr_t;

endpackage

### design/interval_table_insert_merge_query.sv
// Interval table of signed inclusive ranges with insert-and-merge and point query.
// Depends on itiq_pkg, itiq_cell and interval_table_insert_merge_query_defines.svh.
//
// A transaction is taken when start is high and busy is low; busy then stays high
// until its result appears. Each transaction walks the row of ENTRIES cells one cell per
// cycle, so its result is shown on rsp_o, with done_o high, for exactly one cycle, after
// the entry register, every cell register and the result register. The receiver cannot
// hold results off, so it must take rsp_o in the cycle that done_o is high. busy falls as
// the result appears, so the next transaction may be started in that same cycle; a new
// transaction is not taken while the last one is still in the row. Stored ranges hold no
// reset value; only entries below the fill count are ever consulted.
`include "interval_table_insert_merge_query_defines.svh"

module interval_table_insert_merge_query #(
  parameter int ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  itiq_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output itiq_pkg::rsp_t rsp_o
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic               accept;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  itiq_pkg::rsp_t     rsp_q, rsp_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               tok_vld_q;
  itiq_pkg::tok_t     tok_q;
  logic               tok_vld [ENTRIES+1];
  itiq_pkg::tok_t     tok     [ENTRIES+1];
  itiq_pkg::tok_t     last;
  logic               last_vld;
  logic               append;
  logic               full;

  assign accept   = start && !busy_q;
  assign last     = tok[ENTRIES];
  assign last_vld = tok_vld[ENTRIES];
  assign full     = (count_q == CNT_W'(ENTRIES));
  assign append   = last_vld && (last.cmd == itiq_pkg::CMD_INSERT) && !last.err &&
                    !last.found && !full;

  // Entry register for the row of cells.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q.cmd   <= req_i.cmd;
      tok_q.lo    <= req_i.lo;
      tok_q.hi    <= req_i.hi;
      tok_q.found <= 1'b0;
      tok_q.err   <= (req_i.cmd == itiq_pkg::CMD_INSERT) &&
                     ($signed(req_i.lo) > $signed(req_i.hi));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= accept;
    end
  end

  assign tok_vld[0] = tok_vld_q;
  assign tok[0]     = tok_q;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    itiq_pkg::wr_t wr;
    logic          occupied;

    assign occupied = (count_q > CNT_W'(i));
    assign wr.en    = append && (count_q == CNT_W'(i));
    assign wr.lo    = last.lo;
    assign wr.hi    = last.hi;

    itiq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .occupied_i (occupied),
      .tok_vld_i  (tok_vld[i]),
      .tok_i      (tok[i]),
      .wr_i       (wr),
      .tok_vld_o  (tok_vld[i+1]),
      .tok_o      (tok[i+1])
    );
  end

  // Result of the transaction leaving the last cell.
  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    done_d  = last_vld;
    rsp_d   = rsp_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (last_vld) begin
      busy_d      = 1'b0;
      rsp_d.hit   = 1'b0;
      rsp_d.status = itiq_pkg::STATUS_OK;
      case (last.cmd)
        itiq_pkg::CMD_QUERY: begin
          rsp_d.hit = last.found;
        end
        itiq_pkg::CMD_INSERT: begin
          if (last.err) begin
            rsp_d.status = itiq_pkg::STATUS_INVERTED;
          end else if (!last.found) begin
            if (full) begin
              rsp_d.status = itiq_pkg::STATUS_FULL;
            end else begin
              rsp_d.hit = 1'b1;
              count_d   = count_q + CNT_W'(1);
            end
          end
        end
        default: begin
          rsp_d.status = itiq_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ITIQ_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(ENTRIES), "fill count beyond table size")
  `ITIQ_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy_q, "busy not raised after a transaction was taken")
  `ITIQ_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, !busy_q, "result shown while still busy")
  `ITIQ_ASSERT_IMP(a_err_no_hit, clk_i, rst_ni, done_q && (rsp_q.status != itiq_pkg::STATUS_OK), !rsp_q.hit, "error result with hit set")
  `ITIQ_ASSERT_NXT(a_append_count, clk_i, rst_ni, append, done_q && rsp_q.hit && (count_q == $past(count_q) + CNT_W'(1)), "append without matching count step")

endmodule

### design/itiq_cell.sv
// One entry of the interval table: holds a range and tests the passing transaction.
// Depends on itiq_pkg.
module itiq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            occupied_i,
  input  logic            tok_vld_i,
  input  itiq_pkg::tok_t  tok_i,
  input  itiq_pkg::wr_t   wr_i,
  output logic            tok_vld_o,
  output itiq_pkg::tok_t  tok_o
);

  logic signed [63:0] lo_q, lo_d;
  logic signed [63:0] hi_q, hi_d;
  logic               tok_vld_q;
  itiq_pkg::tok_t     tok_q, tok_d;
  logic               live;
  logic               covers;
  logic               overlaps;

  assign live     = tok_vld_i && occupied_i && !tok_i.found && !tok_i.err;
  assign covers   = ($signed(lo_q) <= $signed(tok_i.lo)) && ($signed(tok_i.lo) <= $signed(hi_q));
  assign overlaps = !(($signed(tok_i.hi) < $signed(lo_q)) || ($signed(tok_i.lo) > $signed(hi_q)));

  always_comb begin
    lo_d  = lo_q;
    hi_d  = hi_q;
    tok_d = tok_i;
    if (wr_i.en) begin
      lo_d = wr_i.lo;
      hi_d = wr_i.hi;
    end else if (live) begin
      case (tok_i.cmd)
        itiq_pkg::CMD_QUERY: begin
          if (covers) begin
            tok_d.found = 1'b1;
          end
        end
        itiq_pkg::CMD_INSERT: begin
          if (overlaps) begin
            tok_d.found = 1'b1;
            // Widen this entry so that it also covers the new range.
            if ($signed(tok_i.lo) < $signed(lo_q)) begin
              lo_d = tok_i.lo;
            end
            if ($signed(tok_i.hi) > $signed(hi_q)) begin
              hi_d = tok_i.hi;
            end
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule
